[design/slp_pkg.sv]
// Shared types, constants and codes for the serial flash page loader.
`timescale 1ns / 1ps

package slp_pkg;

    localparam int PAGE_BYTES_DEF      = 128;
    localparam int PAGE_INDEX_BITS_DEF = 7;
    localparam int CMD_Q_DEPTH         = 2;

    // input item kinds
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_BYTE  = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    // result actions
    localparam logic [2:0] ACT_SEND  = 3'd0;
    localparam logic [2:0] ACT_LOAD  = 3'd1;
    localparam logic [2:0] ACT_ERASE = 3'd2;
    localparam logic [2:0] ACT_WRITE = 3'd3;
    localparam logic [2:0] ACT_START = 3'd4;

    // protocol characters
    localparam logic [7:0] CH_PROG  = 8'h70;  // 'p'
    localparam logic [7:0] CH_WROTE = 8'h77;  // 'w'
    localparam logic [7:0] CH_APP   = 8'h61;  // 'a'
    localparam logic [7:0] CH_BOOT  = 8'h62;  // 'b'
    localparam logic [7:0] CH_END   = 8'hFF;

    // configuration register indexes
    localparam logic CFG_PAGE_TOTAL = 1'b0;
    localparam logic CFG_TIMEOUT    = 1'b1;

    localparam logic [7:0] PAGE_TOTAL_RST = 8'd128;
    localparam logic [7:0] TIMEOUT_RST    = 8'd3;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WAIT,
        PH_PAGENUM,
        PH_DATA,
        PH_DONE
    } t_slp_phase;

    // command classes handed from front to back
    typedef enum logic [1:0] {
        CMD_BOOT,   // 'b'
        CMD_START,  // 'a', start application
        CMD_INFO,   // page size, page count
        CMD_PAGE    // optional load word, optional erase/write/'w'
    } t_slp_op;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] rx_byte;
    } t_slp_in;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  tx_byte;
        logic [15:0] word_value;
        logic [6:0]  word_offset;
        logic [13:0] page_address;
        logic        last;
    } t_slp_out;

    typedef struct packed {
        t_slp_op     op;
        logic        load;   // load word present
        logic        fin;    // page complete
        logic [15:0] word;
        logic [6:0]  offset;
        logic [13:0] addr;
        logic [7:0]  total;
    } t_slp_cmd;

endpackage

[design/slp_front.sv]
// Front end: protocol state, config registers, classifies words into commands.
`timescale 1ns / 1ps

module slp_front
    import slp_pkg::*;
#(
    parameter int PAGE_BYTES      = PAGE_BYTES_DEF,
    parameter int PAGE_INDEX_BITS = PAGE_INDEX_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_push,
    input  t_slp_in    i_item,
    input  logic       i_q_full,
    output logic       o_cmd_push,
    output t_slp_cmd   o_cmd
);

    localparam int BC_W = $clog2(PAGE_BYTES);

    t_slp_phase                 r_phase, n_phase;
    logic [7:0]                 r_tick_count, n_tick_count;
    logic [PAGE_INDEX_BITS-1:0] r_page_index, n_page_index;
    logic [BC_W-1:0]            r_byte_count, n_byte_count;
    logic [7:0]                 r_low_half, n_low_half;
    logic [7:0]                 r_page_total;
    logic [7:0]                 r_timeout;

    logic        accept;
    logic [7:0]  tick_inc;
    logic [13:0] page_addr;

    assign accept    = i_push && !i_q_full;
    assign tick_inc  = r_tick_count + 8'd1;
    assign page_addr = 14'(32'(r_page_index) * 32'(PAGE_BYTES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_total <= PAGE_TOTAL_RST;
            r_timeout    <= TIMEOUT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PAGE_TOTAL: r_page_total <= i_cfg_wdata;
                CFG_TIMEOUT:    r_timeout    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_tick_count <= '0;
            r_page_index <= '0;
            r_byte_count <= '0;
            r_low_half   <= '0;
        end else begin
            r_phase      <= n_phase;
            r_tick_count <= n_tick_count;
            r_page_index <= n_page_index;
            r_byte_count <= n_byte_count;
            r_low_half   <= n_low_half;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_tick_count = r_tick_count;
        n_page_index = r_page_index;
        n_byte_count = r_byte_count;
        n_low_half   = r_low_half;
        o_cmd_push   = 1'b0;
        o_cmd        = '0;
        o_cmd.total  = r_page_total;
        o_cmd.addr   = page_addr;
        if (accept) begin
            case (i_item.kind)
                KIND_START: begin
                    if (r_phase == PH_IDLE) begin
                        o_cmd.op     = CMD_BOOT;
                        o_cmd_push   = 1'b1;
                        n_tick_count = '0;
                        n_phase      = PH_WAIT;
                    end
                end
                KIND_TICK: begin
                    if (r_phase == PH_WAIT) begin
                        n_tick_count = tick_inc;
                        if (tick_inc == r_timeout) begin
                            o_cmd.op   = CMD_START;
                            o_cmd_push = 1'b1;
                            n_phase    = PH_DONE;
                        end
                    end
                end
                KIND_BYTE: begin
                    case (r_phase)
                        PH_WAIT: begin
                            if (i_item.rx_byte == CH_PROG) begin
                                o_cmd.op   = CMD_INFO;
                                o_cmd_push = 1'b1;
                                n_phase    = PH_PAGENUM;
                            end
                        end
                        PH_PAGENUM: begin
                            if (i_item.rx_byte == CH_END) begin
                                o_cmd.op   = CMD_START;
                                o_cmd_push = 1'b1;
                                n_phase    = PH_DONE;
                            end else begin
                                n_page_index = i_item.rx_byte[PAGE_INDEX_BITS-1:0];
                                n_byte_count = '0;
                                n_low_half   = '0;
                                n_phase      = PH_DATA;
                            end
                        end
                        PH_DATA: begin
                            o_cmd.op = CMD_PAGE;
                            if (!r_byte_count[0]) begin
                                n_low_half = i_item.rx_byte;
                            end else begin
                                o_cmd.load   = 1'b1;
                                o_cmd.word   = {i_item.rx_byte, r_low_half};
                                o_cmd.offset = 7'(r_byte_count >> 1);
                            end
                            if (r_byte_count == BC_W'(PAGE_BYTES - 1)) begin
                                o_cmd.fin    = 1'b1;
                                n_byte_count = '0;
                                n_low_half   = '0;
                                n_phase      = PH_PAGENUM;
                            end else begin
                                n_byte_count = BC_W'(r_byte_count + 1'b1);
                            end
                            o_cmd_push = o_cmd.load || o_cmd.fin;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // once the application is started nothing brings the engine back
    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE) |=> (r_phase == PH_DONE))
        else $error("left done phase");

    // tick counter only moves in the wait phase or on start
    a_tick_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAGENUM || r_phase == PH_DATA || r_phase == PH_DONE)
        |=> $stable(r_tick_count))
        else $error("tick count moved outside wait");

endmodule

[design/slp_cmd_fifo.sv]
// Short command queue between the front end and the result expander.
`timescale 1ns / 1ps

module slp_cmd_fifo
    import slp_pkg::*;
#(
    parameter int DEPTH = CMD_Q_DEPTH
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_slp_cmd i_data,
    input  logic     i_pop,
    output t_slp_cmd o_head,
    output logic     o_full,
    output logic     o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_slp_cmd         r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_wr_ptr + 1'b1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_rd_ptr + 1'b1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= CNT_W'(r_count + 1'b1);
                2'b01:   r_count <= CNT_W'(r_count - 1'b1);
                default: r_count <= r_count;
            endcase
        end
    end

    // the front end must only produce a command when it accepted a word
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("command pushed into full queue");

endmodule

[design/slp_back.sv]
// Back end: expands one command into its result words, one per cycle while the output is popped.
`timescale 1ns / 1ps

module slp_back
    import slp_pkg::*;
#(
    parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_slp_cmd i_head,
    input  logic     i_q_empty,
    output logic     o_q_pop,
    input  logic     i_pop,
    output logic     o_empty,
    output t_slp_out o_result
);

    localparam logic [1:0] SLOT_LOAD  = 2'd0;
    localparam logic [1:0] SLOT_ERASE = 2'd1;
    localparam logic [1:0] SLOT_WRITE = 2'd2;
    localparam logic [1:0] SLOT_ACK   = 2'd3;

    logic [1:0] r_step;
    t_slp_out   r_out;
    logic       r_out_valid;

    t_slp_out   res;
    logic [1:0] slot;
    logic       advance;

    assign advance  = !r_out_valid || i_pop;
    assign o_q_pop  = advance && !i_q_empty && res.last;
    assign o_empty  = !r_out_valid;
    assign o_result = r_out;
    // page commands without a load word start at the erase
    assign slot     = i_head.load ? r_step : 2'(r_step + 2'd1);

    always_comb begin
        res = '0;
        case (i_head.op)
            CMD_BOOT: begin
                res.action  = ACT_SEND;
                res.tx_byte = CH_BOOT;
                res.last    = 1'b1;
            end
            CMD_START: begin
                if (r_step == 2'd0) begin
                    res.action  = ACT_SEND;
                    res.tx_byte = CH_APP;
                end else begin
                    res.action = ACT_START;
                    res.last   = 1'b1;
                end
            end
            CMD_INFO: begin
                res.action = ACT_SEND;
                if (r_step == 2'd0) begin
                    res.tx_byte = 8'(PAGE_BYTES);
                end else begin
                    res.tx_byte = i_head.total;
                    res.last    = 1'b1;
                end
            end
            CMD_PAGE: begin
                case (slot)
                    SLOT_LOAD: begin
                        res.action       = ACT_LOAD;
                        res.word_value   = i_head.word;
                        res.word_offset  = i_head.offset;
                        res.page_address = i_head.addr;
                        res.last         = !i_head.fin;
                    end
                    SLOT_ERASE: begin
                        res.action       = ACT_ERASE;
                        res.page_address = i_head.addr;
                    end
                    SLOT_WRITE: begin
                        res.action       = ACT_WRITE;
                        res.page_address = i_head.addr;
                    end
                    SLOT_ACK: begin
                        res.action  = ACT_SEND;
                        res.tx_byte = CH_WROTE;
                        res.last    = 1'b1;
                    end
                    default: res.last = 1'b1;
                endcase
            end
            default: res.last = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (advance && !i_q_empty) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= !i_q_empty;
            if (!i_q_empty) begin
                r_step <= res.last ? 2'd0 : 2'(r_step + 2'd1);
            end
        end
    end

    // a command being expanded stays at the queue head until its last word
    a_step_has_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != 2'd0) |-> !i_q_empty)
        else $error("expansion step without a command");

endmodule

[design/serial_flash_page_loader.sv]
// Top level of the serial flash page loader protocol engine.
//
//  channel   direction  handshake                 payload
//  items     in         push / full               i_item   (t_slp_in)
//  results   out        empty / pop               o_result (t_slp_out)
//  config    in         i_cfg_we, i_cfg_idx       i_cfg_wdata
//
// An item is taken in any cycle in which the two-entry command queue has room.
// Results leave at one word per cycle from the expander while the receiver
// pops; an item yields 0 to 4 words (page end with a load word gives four).
// Reset is synchronous and active low; it clears protocol state, config
// registers to their defaults, the command queue and the output register.
// A stalled result holds there while the front accepts until the queue fills.
`timescale 1ns / 1ps

module serial_flash_page_loader
    import slp_pkg::*;
#(
    parameter int PAGE_BYTES      = PAGE_BYTES_DEF,
    parameter int PAGE_INDEX_BITS = PAGE_INDEX_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_wdata,
    input  logic       push,
    output logic       full,
    input  t_slp_in    i_item,
    output logic       empty,
    input  logic       pop,
    output t_slp_out   o_result
);

    logic     cmd_push;
    t_slp_cmd cmd;
    t_slp_cmd head;
    logic     q_full;
    logic     q_empty;
    logic     q_pop;

    assign full = q_full;

    slp_front #(
        .PAGE_BYTES      (PAGE_BYTES),
        .PAGE_INDEX_BITS (PAGE_INDEX_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_push      (push),
        .i_item      (i_item),
        .i_q_full    (q_full),
        .o_cmd_push  (cmd_push),
        .o_cmd       (cmd)
    );

    slp_cmd_fifo #(
        .DEPTH (CMD_Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd),
        .i_pop   (q_pop),
        .o_head  (head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    slp_back #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (head),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result)
    );

endmodule

[verif/tb.sv]
// Self-checking testbench for the serial flash page loader protocol engine.
`timescale 1ns / 1ps

module tb;
    import slp_pkg::*;

    localparam int PG_BYTES       = PAGE_BYTES_DEF;
    localparam int HOLD_CYCLES    = 200;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 80;

    localparam logic [1:0] KIND_NONE = 2'd3;  // undefined kind, block drops it

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic       i_cfg_idx   = CFG_PAGE_TOTAL;
    logic [7:0] i_cfg_wdata = 8'd0;
    logic       push        = 1'b0;
    logic       full;
    t_slp_in    i_item      = '0;
    logic       empty;
    logic       pop         = 1'b0;
    t_slp_out   o_result;

    serial_flash_page_loader uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // loader state as the host protocol sees it
    t_slp_phase ld_phase       = PH_IDLE;
    logic [7:0] ld_ticks       = 8'd0;
    logic [6:0] ld_page        = 7'd0;
    logic [7:0] ld_count       = 8'd0;
    logic [7:0] ld_low         = 8'd0;
    logic [7:0] reg_page_total = PAGE_TOTAL_RST;
    logic [7:0] reg_timeout    = TIMEOUT_RST;

    t_slp_in  pending_items[$];
    t_slp_out exp_words[$];

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    bit  pressure       = 1'b0;
    int  hold_cnt       = 0;
    int  mismatches     = 0;
    int  idle_cycles    = 0;
    int  pg_left        = 0;

    function automatic void predict_loader(input t_slp_in it);
        t_slp_out   outs[4];
        int         n;
        logic [7:0] b;
        logic [7:0] pos;
        logic [13:0] addr;
        outs = '{default: '0};
        n    = 0;
        b    = it.rx_byte;
        addr = 14'(int'(ld_page) * PG_BYTES);
        case (it.kind)
            KIND_START: begin
                if (ld_phase == PH_IDLE) begin
                    outs[n].action  = ACT_SEND;
                    outs[n].tx_byte = CH_BOOT;
                    n++;
                    ld_ticks = 8'd0;
                    ld_phase = PH_WAIT;
                end
            end
            KIND_TICK: begin
                if (ld_phase == PH_WAIT) begin
                    ld_ticks = ld_ticks + 8'd1;
                    if (ld_ticks == reg_timeout) begin
                        outs[n].action  = ACT_SEND;
                        outs[n].tx_byte = CH_APP;
                        n++;
                        outs[n].action  = ACT_START;
                        n++;
                        ld_phase = PH_DONE;
                    end
                end
            end
            KIND_BYTE: begin
                if (ld_phase == PH_WAIT) begin
                    if (b == CH_PROG) begin
                        outs[n].action  = ACT_SEND;
                        outs[n].tx_byte = 8'(PG_BYTES);
                        n++;
                        outs[n].action  = ACT_SEND;
                        outs[n].tx_byte = reg_page_total;
                        n++;
                        ld_phase = PH_PAGENUM;
                    end
                end else if (ld_phase == PH_PAGENUM) begin
                    if (b == CH_END) begin
                        outs[n].action  = ACT_SEND;
                        outs[n].tx_byte = CH_APP;
                        n++;
                        outs[n].action  = ACT_START;
                        n++;
                        ld_phase = PH_DONE;
                    end else begin
                        ld_page  = b[6:0];
                        ld_count = 8'd0;
                        ld_low   = 8'd0;
                        ld_phase = PH_DATA;
                    end
                end else if (ld_phase == PH_DATA) begin
                    pos = ld_count;
                    if (!pos[0]) begin
                        ld_low = b;
                    end else begin
                        outs[n].action       = ACT_LOAD;
                        outs[n].word_value   = {b, ld_low};
                        outs[n].word_offset  = pos[7:1];
                        outs[n].page_address = addr;
                        n++;
                    end
                    ld_count = pos + 8'd1;
                    if (int'(pos) + 1 >= PG_BYTES) begin
                        outs[n].action       = ACT_ERASE;
                        outs[n].page_address = addr;
                        n++;
                        outs[n].action       = ACT_WRITE;
                        outs[n].page_address = addr;
                        n++;
                        outs[n].action  = ACT_SEND;
                        outs[n].tx_byte = CH_WROTE;
                        n++;
                        ld_count = 8'd0;
                        ld_low   = 8'd0;
                        ld_phase = PH_PAGENUM;
                    end
                end
            end
            default: ;
        endcase
        for (int k = 0; k < n; k++) begin
            outs[k].last = (k == n - 1);
            exp_words.push_back(outs[k]);
        end
    endfunction

    // driver: offers queued items, predicts each one as it is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                predict_loader(i_item);
            end
            if (!push || !full) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_item <= pending_items.pop_front();
                    push   <= 1'b1;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each popped word against the oldest prediction
    always @(posedge i_clk) begin
        t_slp_out want;
        if (!i_rst_n) begin
            pop      <= 1'b0;
            hold_cnt <= 0;
        end else begin
            if (pop && !empty) begin
                if (exp_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected word: act=%0d tx=%h word=%h off=%0d addr=%h last=%b",
                                 o_result.action, o_result.tx_byte, o_result.word_value,
                                 o_result.word_offset, o_result.page_address, o_result.last);
                    end
                end else begin
                    want = exp_words.pop_front();
                    if (o_result.action !== want.action || o_result.tx_byte !== want.tx_byte
                        || o_result.word_value !== want.word_value
                        || o_result.word_offset !== want.word_offset
                        || o_result.page_address !== want.page_address
                        || o_result.last !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: want act=%0d tx=%h word=%h off=%0d addr=%h last=%b",
                                     want.action, want.tx_byte, want.word_value,
                                     want.word_offset, want.page_address, want.last);
                            $display("          got  act=%0d tx=%h word=%h off=%0d addr=%h last=%b",
                                     o_result.action, o_result.tx_byte, o_result.word_value,
                                     o_result.word_offset, o_result.page_address, o_result.last);
                        end
                    end
                end
            end
            if (pressure && hold_cnt < HOLD_CYCLES) begin
                // long hold-off so the item side backs up
                hold_cnt <= hold_cnt + 1;
                pop      <= 1'b0;
            end else begin
                if (!pressure) hold_cnt <= 0;
                pop <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic put(input logic [1:0] kind, input logic [7:0] rx);
        t_slp_in it;
        it.kind    = kind;
        it.rx_byte = rx;
        pending_items.push_back(it);
    endtask

    function automatic logic [7:0] pick_data();
        case ($urandom_range(9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // page number: never the end marker, biased to the edges of the index
    function automatic logic [7:0] pick_page();
        case ($urandom_range(9))
            0: return 8'h00;
            1: return 8'hFE;
            2: return 8'h7F;
            3: return 8'h80;
            default: return 8'($urandom_range(254));
        endcase
    endfunction

    task automatic put_noise();
        case ($urandom_range(2))
            0: put(KIND_START, 8'($urandom_range(255)));
            1: put(KIND_TICK, 8'($urandom_range(255)));
            default: put(KIND_NONE, 8'($urandom_range(255)));
        endcase
    endtask

    // page sessions with random content, sprinkled with ignored items
    task automatic put_pages(input int count);
        int made;
        made = 0;
        while (made < count) begin
            if ($urandom_range(9) == 0) begin
                put_noise();
            end else begin
                if (pg_left == 0) begin
                    put(KIND_BYTE, pick_page());
                    pg_left = PG_BYTES;
                end else begin
                    put(KIND_BYTE, pick_data());
                    pg_left--;
                end
                made++;
            end
        end
    endtask

    task automatic wait_quiet();
        @(negedge i_clk);
        while (pending_items.size() != 0 || push || exp_words.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_regs(input logic [7:0] total, input logic [7:0] ticks);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_PAGE_TOTAL;
        i_cfg_wdata <= total;
        reg_page_total = total;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_TIMEOUT;
        i_cfg_wdata <= ticks;
        reg_timeout = ticks;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_regs(8'd1, 8'd255);

        // before start everything is dropped, then boot and the wait
        put(KIND_TICK, 8'h00);
        put(KIND_BYTE, CH_PROG);
        put(KIND_NONE, 8'hFF);
        put(KIND_BYTE, CH_END);
        put(KIND_START, 8'h00);
        put(KIND_START, 8'hFF);
        put(KIND_TICK, 8'hFF);
        put(KIND_TICK, 8'h55);
        put(KIND_TICK, 8'hAA);
        put(KIND_BYTE, 8'h00);
        put(KIND_BYTE, 8'hFF);
        put(KIND_BYTE, 8'h50);
        put(KIND_BYTE, 8'h71);
        put(KIND_NONE, 8'h00);
        wait_quiet();
        write_regs(8'd255, 8'd1);

        // program request, top page index masked, extreme data words
        put(KIND_BYTE, CH_PROG);
        put(KIND_BYTE, 8'hFE);
        put(KIND_BYTE, 8'hFF);
        put(KIND_BYTE, 8'hFF);
        put(KIND_TICK, 8'h00);
        put(KIND_BYTE, 8'h00);
        put(KIND_START, 8'h00);
        put(KIND_BYTE, 8'h00);
        put(KIND_NONE, 8'hFF);
        pg_left = PG_BYTES - 4;
        wait_quiet();
        write_regs(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));

        // no idling, with a long result hold-off at the start
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        pressure       = 1'b1;
        put_pages(PHASE_ITEMS);
        wait_quiet();
        pressure = 1'b0;
        write_regs(8'd1, 8'd255);

        send_idle_pct  = 81;
        recv_stall_pct = 0;
        put_pages(PHASE_ITEMS);
        wait_quiet();
        write_regs(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));

        send_idle_pct  = 0;
        recv_stall_pct = 81;
        put_pages(PHASE_ITEMS);
        wait_quiet();
        write_regs(8'd255, 8'd1);

        send_idle_pct  = 15;
        recv_stall_pct = 15;
        put_pages(PHASE_ITEMS);
        while (pg_left > 0) begin
            put(KIND_BYTE, pick_data());
            pg_left--;
        end
        // end of programming, then nothing is answered any more
        put(KIND_BYTE, CH_END);
        put(KIND_START, 8'h00);
        put(KIND_BYTE, CH_PROG);
        put(KIND_TICK, 8'h00);
        put(KIND_BYTE, CH_END);
        put(KIND_NONE, 8'h5A);
        wait_quiet();

        if (mismatches == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
